[hw/rtl/hsvh_pkg.sv]
package hsvh_pkg;

	// Request function codes
	typedef enum logic [1:0] {
		FUNC_ACC   = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_CLEAR = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_RDM,
		ST_WRM,
		ST_FETCH,
		ST_RESULT,
		ST_WIPE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic clr_adv;
		logic rd_acc;
		logic wr_acc;
		logic step_adv;
		logic rd_bin;
		logic wr_bin;
		logic out_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_done;
		logic step_live;
		logic step_last;
		logic out_free;
	} sts_t;

	localparam int OUT_W = 33;
	localparam int WGT_W = 25;
	localparam logic [8:0] Q8_ONE = 9'd256;
	localparam logic [7:0] HALF_Q8 = 8'd128;

endpackage

[hw/rtl/hsvh_ram.sv]
module hsvh_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 110592
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/hsvh_ctrl.sv]
module hsvh_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  hsvh_pkg::func_t func,
	input  hsvh_pkg::sts_t  sts,
	output logic            in_stall,
	output hsvh_pkg::cmd_t  cmd
);

	import hsvh_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_done) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (func)
						FUNC_ACC:   state_nxt = ST_SCAN;
						FUNC_READ:  state_nxt = ST_FETCH;
						FUNC_CLEAR: state_nxt = ST_WIPE;
						default:    state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				if (sts.step_live) begin
					state_nxt = ST_RDM;
				end else if (sts.step_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_RDM: state_nxt = ST_WRM;
			ST_WRM: begin
				state_nxt = sts.step_last ? ST_IDLE : ST_SCAN;
			end
			ST_FETCH: state_nxt = ST_RESULT;
			ST_RESULT: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_WIPE: state_nxt = ST_IDLE;
			default: state_nxt = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_CLEAR: cmd.clr_adv = 1'b1;
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_SCAN: cmd.step_adv = ~sts.step_live;
			ST_RDM:  cmd.rd_acc = 1'b1;
			ST_WRM: begin
				cmd.wr_acc   = 1'b1;
				cmd.step_adv = 1'b1;
			end
			ST_FETCH:  cmd.rd_bin = 1'b1;
			ST_RESULT: cmd.out_load = sts.out_free;
			ST_WIPE:   cmd.wr_bin = 1'b1;
			default: begin
				cmd      = '0;
				in_stall = 1'b1;
			end
		endcase
	end

	// A write-back always follows the read of the same neighbour
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_acc |-> $past(cmd.rd_acc))
	else $error("accumulator write without preceding read");

	// Single-port memory: at most one access kind per cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_adv, cmd.rd_acc, cmd.wr_acc, cmd.rd_bin, cmd.wr_bin}))
	else $error("conflicting memory accesses");

	// Never overwrite a result that is still stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
	else $error("result loaded over a pending result");

	// An accepted read request reaches the result slot by way of the fetch state
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && func == FUNC_READ) |=> ##1 (state_q == ST_RESULT))
	else $error("read request lost its result slot");

endmodule

[hw/rtl/hsvh_dp.sv]
module hsvh_dp #(
	parameter int CELLS         = 4096,
	parameter int BINS_PER_AXIS = 3,
	parameter int ACC_WIDTH     = 33,
	localparam int NBINS = BINS_PER_AXIS * BINS_PER_AXIS * BINS_PER_AXIS,
	localparam int DEPTH = CELLS * NBINS,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  hsvh_pkg::cmd_t               cmd,
	output hsvh_pkg::sts_t               sts,
	input  logic                         cfg_wr_en,
	input  logic                         cfg_wr_data,
	input  logic [7:0]                   hue_code,
	input  logic [7:0]                   sat_code,
	input  logic [7:0]                   val_code,
	input  logic [11:0]                  cell_index,
	input  logic [4:0]                   bin_index,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [hsvh_pkg::OUT_W-1:0]   bin_value,
	output logic                         ram_en,
	output logic                         ram_we,
	output logic [AW-1:0]                ram_addr,
	output logic [ACC_WIDTH-1:0]         ram_wdata,
	input  logic [ACC_WIDTH-1:0]         ram_rdata
);

	import hsvh_pkg::*;

	localparam int B    = BINS_PER_AXIS;
	localparam int TW   = 8 + $clog2(B + 1);
	localparam int UW   = TW - 8;
	localparam int BW   = $clog2(B);
	localparam int SBW  = $clog2(NBINS);
	localparam int SUMW = ACC_WIDTH + 1;
	localparam int EXTW = OUT_W + ACC_WIDTH;
	localparam logic [16:0] CELLS_L = 17'(CELLS);
	localparam logic [9:0]  NBINS_L = 10'(NBINS);

	function automatic logic [UW-1:0] axis_floor(input logic [7:0] code);
		logic [TW-1:0] t;
		t = TW'(code) * TW'(B) + TW'(HALF_Q8);
		return t[TW-1:8];
	endfunction

	function automatic logic [7:0] axis_frac(input logic [7:0] code);
		logic [TW-1:0] t;
		t = TW'(code) * TW'(B) + TW'(HALF_Q8);
		return t[7:0];
	endfunction

	function automatic logic [BW-1:0] axis_hard(input logic [7:0] code);
		logic [TW-1:0] t;
		t = TW'(code) * TW'(B);
		return BW'(t[TW-1:8]);
	endfunction

	logic            interp_q;
	logic [AW-1:0]   clr_q;
	logic [2:0]      step_q;
	logic            out_valid_q;
	logic [OUT_W-1:0] bin_value_q;

	logic [AW-1:0]   base_q;
	logic [SBW-1:0]  bin_q;
	logic            bin_ok_q;
	logic [BW-1:0]   xb_q [2];
	logic [BW-1:0]   yb_q [2];
	logic [BW-1:0]   zb_q [2];
	logic [8:0]      xw_q [2];
	logic [8:0]      yw_q [2];
	logic [8:0]      zw_q [2];
	logic [1:0]      xv_q;
	logic [1:0]      yv_q;
	logic [1:0]      zv_q;
	logic [17:0]     p_s1;

	logic [UW-1:0]   xu, yu, zu;
	logic [7:0]      xf, yf, zf;
	logic            cell_ok;
	logic [BW-1:0]   xs, ys, zs;
	logic [SBW-1:0]  step_bin;
	logic [AW-1:0]   step_addr;
	logic [26:0]     wprod;
	logic [SUMW-1:0] sum;
	logic [ACC_WIDTH-1:0] sat_sum;
	logic [EXTW-1:0] rd_ext;

	always_comb begin
		xu = axis_floor(hue_code);
		yu = axis_floor(sat_code);
		zu = axis_floor(val_code);
		xf = axis_frac(hue_code);
		yf = axis_frac(sat_code);
		zf = axis_frac(val_code);
		cell_ok = 17'(cell_index) < CELLS_L;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interp_q    <= 1'b1;
			clr_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				interp_q <= cfg_wr_data;
			end
			if (cmd.clr_adv) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.load) begin
				step_q <= '0;
			end else if (cmd.step_adv) begin
				step_q <= step_q + 3'd1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the request and split each axis into neighbour bins and weights
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q   <= AW'(cell_index) * AW'(NBINS);
			bin_q    <= SBW'(bin_index);
			bin_ok_q <= cell_ok && (10'(bin_index) < NBINS_L);
			if (interp_q) begin
				xb_q[0] <= (xu == '0) ? BW'(B - 1) : BW'(xu - UW'(1));
				xb_q[1] <= (xu == UW'(B)) ? '0 : BW'(xu);
				yb_q[0] <= BW'(yu - UW'(1));
				yb_q[1] <= BW'(yu);
				zb_q[0] <= BW'(zu - UW'(1));
				zb_q[1] <= BW'(zu);
				xw_q[0] <= Q8_ONE - 9'(xf);
				xw_q[1] <= 9'(xf);
				yw_q[0] <= Q8_ONE - 9'(yf);
				yw_q[1] <= 9'(yf);
				zw_q[0] <= Q8_ONE - 9'(zf);
				zw_q[1] <= 9'(zf);
				xv_q    <= 2'b11;
				yv_q    <= {yu != UW'(B), yu != '0};
				zv_q    <= {zu != UW'(B), zu != '0} & {2{cell_ok}};
			end else begin
				xb_q[0] <= axis_hard(hue_code);
				xb_q[1] <= '0;
				yb_q[0] <= axis_hard(sat_code);
				yb_q[1] <= '0;
				zb_q[0] <= axis_hard(val_code);
				zb_q[1] <= '0;
				xw_q[0] <= Q8_ONE;
				xw_q[1] <= '0;
				yw_q[0] <= Q8_ONE;
				yw_q[1] <= '0;
				zw_q[0] <= Q8_ONE;
				zw_q[1] <= '0;
				xv_q    <= 2'b01;
				yv_q    <= 2'b01;
				zv_q    <= {1'b0, cell_ok};
			end
		end
		if (cmd.rd_acc) begin
			p_s1 <= 18'(xw_q[step_q[0]]) * 18'(yw_q[step_q[1]]);
		end
		if (cmd.out_load) begin
			bin_value_q <= bin_ok_q ? rd_ext[OUT_W-1:0] : '0;
		end
	end

	// Neighbour order: value outermost, hue innermost
	always_comb begin
		xs = xb_q[step_q[0]];
		ys = yb_q[step_q[1]];
		zs = zb_q[step_q[2]];
		step_bin  = SBW'(zs) * SBW'(B * B) + SBW'(ys) * SBW'(B) + SBW'(xs);
		step_addr = base_q + AW'(step_bin);
		wprod     = 27'(p_s1) * 27'(zw_q[step_q[2]]);
		sum       = {1'b0, ram_rdata} + SUMW'(wprod[WGT_W-1:0]);
		sat_sum   = sum[ACC_WIDTH] ? '1 : sum[ACC_WIDTH-1:0];
		rd_ext    = {{OUT_W{1'b0}}, ram_rdata};
	end

	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = step_addr;
		ram_wdata = '0;
		if (cmd.clr_adv) begin
			ram_en   = 1'b1;
			ram_we   = 1'b1;
			ram_addr = clr_q;
		end else if (cmd.rd_acc) begin
			ram_en = 1'b1;
		end else if (cmd.wr_acc) begin
			ram_en    = 1'b1;
			ram_we    = 1'b1;
			ram_wdata = sat_sum;
		end else if (cmd.rd_bin || cmd.wr_bin) begin
			ram_en   = bin_ok_q;
			ram_we   = cmd.wr_bin;
			ram_addr = base_q + AW'(bin_q);
		end
	end

	always_comb begin
		sts.clr_done  = clr_q == AW'(DEPTH - 1);
		sts.step_live = zv_q[step_q[2]] & yv_q[step_q[1]] & xv_q[step_q[0]];
		sts.step_last = step_q == 3'd7;
		sts.out_free  = ~out_valid_q | ~out_stall;
	end

	assign out_valid = out_valid_q;
	assign bin_value = bin_value_q;

	// Memory accesses stay inside the store
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_en |-> (32'(ram_addr) < 32'(DEPTH)))
	else $error("memory address out of range");

	// A loaded result is presented on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
	else $error("loaded result not presented");

	// Hard binning casts at most a single full-weight vote
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && !interp_q) |=> ($countones(zv_q) <= 1 && yv_q == 2'b01 && xv_q == 2'b01))
	else $error("hard binning enabled extra neighbours");

endmodule

[hw/rtl/hsv_trilinear_histogram.sv]
// Per-cell B x B x B HSV colour histogram (B = BINS_PER_AXIS, 3 by default)
// held in one single-port memory of CELLS*B^3 saturating Q24 accumulators.
// func 0 casts a pixel vote, func 1 returns one bin on bin_value, func 2 zeroes
// one bin; func 3 is taken and dropped. interp_q (reset 1, set by cfg_wr_data) picks
// trilinear soft voting over eight neighbours, hue wrapping and saturation/value
// neighbours outside the cube dropped; 0 picks one hard vote of 1.0.
// After reset a clearing pass writes zero to every entry, one per cycle;
// requests stall meanwhile but configuration writes are taken. Requests are
// processed one at a time, paced by the read-modify-write on the single memory
// port: a vote is accepted, then each of its eight neighbours gets a scan step,
// and a kept neighbour also a read and a write. A read is accepted, fetched,
// then loaded into the result slot once the previous result is no longer held
// by out_stall; a clear is accepted, then wipes its bin.
module hsv_trilinear_histogram #(
	parameter int CELLS         = 4096,
	parameter int BINS_PER_AXIS = 3,
	parameter int ACC_WIDTH     = 33
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic                       cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 func,
	input  logic [7:0]                 hue_code,
	input  logic [7:0]                 sat_code,
	input  logic [7:0]                 val_code,
	input  logic [11:0]                cell_index,
	input  logic [4:0]                 bin_index,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [hsvh_pkg::OUT_W-1:0] bin_value
);

	import hsvh_pkg::*;

	localparam int NBINS = BINS_PER_AXIS * BINS_PER_AXIS * BINS_PER_AXIS;
	localparam int DEPTH = CELLS * NBINS;
	localparam int AW    = $clog2(DEPTH);

	cmd_t                 cmd;
	sts_t                 sts;
	logic                 ram_en;
	logic                 ram_we;
	logic [AW-1:0]        ram_addr;
	logic [ACC_WIDTH-1:0] ram_wdata;
	logic [ACC_WIDTH-1:0] ram_rdata;

	hsvh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func_t'(func)),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	hsvh_dp #(
		.CELLS         (CELLS),
		.BINS_PER_AXIS (BINS_PER_AXIS),
		.ACC_WIDTH     (ACC_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.hue_code    (hue_code),
		.sat_code    (sat_code),
		.val_code    (val_code),
		.cell_index  (cell_index),
		.bin_index   (bin_index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.bin_value   (bin_value),
		.ram_en      (ram_en),
		.ram_we      (ram_we),
		.ram_addr    (ram_addr),
		.ram_wdata   (ram_wdata),
		.ram_rdata   (ram_rdata)
	);

	hsvh_ram #(
		.WIDTH (ACC_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

endmodule

[tb/hsv_trilinear_histogram_test.sv]
module hsv_trilinear_histogram_test;
	timeunit 1ns;
	timeprecision 1ps;

	import hsvh_pkg::*;

	localparam int CELL_COUNT = 4096;
	localparam int BPA = 3;
	localparam int NBIN = BPA * BPA * BPA;
	localparam logic [32:0] ACC_MAX = {33{1'b1}};
	localparam logic [32:0] ONE_Q24 = 33'd16777216;
	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam int SETTLE_CYCLES = 24;
	localparam int HOLD_OFF_CYCLES = 400;

	typedef struct packed {
		logic [1:0]  fn;
		logic [7:0]  hue;
		logic [7:0]  sat;
		logic [7:0]  val;
		logic [11:0] cell_idx;
		logic [4:0]  bin_idx;
	} pix_req_t;

	typedef struct {
		bit          is_cfg;
		logic        cfg_val;
		pix_req_t    req;
		bit          given;
		logic [32:0] given_value;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic        cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  func;
	logic [7:0]  hue_code;
	logic [7:0]  sat_code;
	logic [7:0]  val_code;
	logic [11:0] cell_index;
	logic [4:0]  bin_index;
	logic        out_valid;
	logic        out_stall;
	logic [OUT_W-1:0] bin_value;

	bit [32:0]   hist_mem [0:CELL_COUNT*NBIN-1];
	logic        interp_mode = 1'b1;
	logic [32:0] read_values_q [$];
	dir_row_t    dir_rows [$];
	int          mismatch_count = 0;
	int          tx_calm_left = 0;
	int          rx_calm_left = 0;
	bit          hold_off_req = 1'b0;

	hsv_trilinear_histogram u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.hue_code   (hue_code),
		.sat_code   (sat_code),
		.val_code   (val_code),
		.cell_index (cell_index),
		.bin_index  (bin_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.bin_value  (bin_value)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [32:0] got,
			input logic [32:0] want);
		$display("%0t: %s bin_value got %0d want %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic add_row(input dir_row_t row);
		dir_rows.insert(dir_rows.size(), row);
	endtask

	task automatic bump_bin(input int unsigned addr, input logic [32:0] w);
		logic [33:0] sum;
		sum = {1'b0, hist_mem[addr]} + {1'b0, w};
		hist_mem[addr] = (sum > {1'b0, ACC_MAX}) ? ACC_MAX : sum[32:0];
	endtask

	task automatic predict_histogram(input pix_req_t r, output logic yields,
			output logic [32:0] value);
		int unsigned base;
		int unsigned t;
		int unsigned wt_lo [3];
		int unsigned wt_hi [3];
		int          lo_b [3];
		int          hi_b [3];
		logic [7:0]  code [3];
		int          a, i, j, k, bx, by, bz;
		int unsigned w;
		yields = 1'b0;
		value = '0;
		base = r.cell_idx * NBIN;
		code[0] = r.hue;
		code[1] = r.sat;
		code[2] = r.val;
		case (r.fn)
			FUNC_READ: begin
				yields = 1'b1;
				if (r.cell_idx < CELL_COUNT && r.bin_idx < NBIN) begin
					value = hist_mem[base + r.bin_idx];
				end
			end
			FUNC_CLEAR: begin
				if (r.cell_idx < CELL_COUNT && r.bin_idx < NBIN) begin
					hist_mem[base + r.bin_idx] = '0;
				end
			end
			FUNC_ACC: begin
				if (r.cell_idx >= CELL_COUNT) begin
				end else if (!interp_mode) begin
					bx = (code[0] * BPA) >> 8;
					by = (code[1] * BPA) >> 8;
					bz = (code[2] * BPA) >> 8;
					bump_bin(base + bz * BPA * BPA + by * BPA + bx, ONE_Q24);
				end else begin
					for (a = 0; a < 3; a++) begin
						t = code[a] * BPA + HALF_Q8;
						hi_b[a] = t >> 8;
						lo_b[a] = hi_b[a] - 1;
						wt_hi[a] = t & 32'hFF;
						wt_lo[a] = Q8_ONE - wt_hi[a];
					end
					// wrap hue neighbours round the circle
					if (lo_b[0] < 0) lo_b[0] = BPA - 1;
					if (hi_b[0] >= BPA) hi_b[0] = 0;
					for (k = 0; k < 2; k++) begin
						bz = k ? hi_b[2] : lo_b[2];
						if (bz < 0 || bz >= BPA) continue;
						for (j = 0; j < 2; j++) begin
							by = j ? hi_b[1] : lo_b[1];
							if (by < 0 || by >= BPA) continue;
							for (i = 0; i < 2; i++) begin
								bx = i ? hi_b[0] : lo_b[0];
								w = (i ? wt_hi[0] : wt_lo[0]) * (j ? wt_hi[1] : wt_lo[1])
									* (k ? wt_hi[2] : wt_lo[2]);
								bump_bin(base + bz * BPA * BPA + by * BPA + bx, 33'(w));
							end
						end
					end
				end
			end
			default: ;
		endcase
	endtask

	function automatic int pick_gap_len();
		if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [11:0] pick_cell();
		case ($urandom_range(0, 7))
			0: return 12'd0;
			1: return 12'd1;
			2: return 12'd2;
			3: return 12'd3;
			4: return 12'd4095;
			5: return 12'($urandom);
			default: return 12'($urandom_range(0, 3));
		endcase
	endfunction

	function automatic logic [7:0] pick_code();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			// land near the points where a coordinate crosses a bin edge
			2, 3: return 8'(42 + 43 * $urandom_range(0, 5) + $urandom_range(0, 1));
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic pix_req_t make_random_request();
		pix_req_t r;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) r.fn = FUNC_ACC;
		else if (roll < 80) r.fn = FUNC_READ;
		else if (roll < 94) r.fn = FUNC_CLEAR;
		else r.fn = FUNC_NONE;
		r.hue = pick_code();
		r.sat = pick_code();
		r.val = pick_code();
		r.cell_idx = pick_cell();
		r.bin_idx = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, NBIN - 1))
			: 5'($urandom_range(NBIN, 31));
		return r;
	endfunction

	function automatic dir_row_t dir_row(input logic [1:0] fn, input logic [7:0] h,
			input logic [7:0] s, input logic [7:0] v, input logic [11:0] c,
			input logic [4:0] b, input bit given, input logic [32:0] gv);
		dir_row_t row;
		row.is_cfg = 1'b0;
		row.cfg_val = 1'b0;
		row.req = '{fn: fn, hue: h, sat: s, val: v, cell_idx: c, bin_idx: b};
		row.given = given;
		row.given_value = gv;
		return row;
	endfunction

	function automatic dir_row_t cfg_row(input logic v);
		dir_row_t row;
		row = dir_row(FUNC_NONE, 8'd0, 8'd0, 8'd0, 12'd0, 5'd0, 1'b0, '0);
		row.is_cfg = 1'b1;
		row.cfg_val = v;
		return row;
	endfunction

	task automatic send_request(input pix_req_t r, input bit given,
			input logic [32:0] given_value);
		logic        yields;
		logic [32:0] v;
		in_valid <= 1'b1;
		func <= r.fn;
		hue_code <= r.hue;
		sat_code <= r.sat;
		val_code <= r.val;
		cell_index <= r.cell_idx;
		bin_index <= r.bin_idx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_histogram(r, yields, v);
		if (yields) read_values_q.insert(read_values_q.size(), given ? given_value : v);
	endtask

	task automatic tx_pause();
		int n;
		if (tx_calm_left > 0) begin
			tx_calm_left--;
		end else if ($urandom_range(0, 19) == 0) begin
			tx_calm_left = $urandom_range(10, 40);
		end else if ($urandom_range(0, 1) == 0) begin
			n = pick_gap_len();
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// hold until every read has come back and the last vote has settled
	task automatic drain_results();
		in_valid <= 1'b0;
		while (read_values_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_interp(input logic v);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		interp_mode = v;
	endtask

	task automatic run_random(input int count);
		int n;
		for (n = 0; n < count; n++) begin
			tx_pause();
			send_request(make_random_request(), 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (read_values_q.size() == 0) begin
				report_mismatch("unexpected result", bin_value, '0);
			end else if (bin_value !== read_values_q[0]) begin
				report_mismatch("wrong", bin_value, read_values_q.pop_front());
			end else begin
				void'(read_values_q.pop_front());
			end
		end
	end

	initial begin : receiver
		int n;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (rx_calm_left > 0) begin
				rx_calm_left--;
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 199) == 0) begin
				rx_calm_left = $urandom_range(50, 300);
			end else if ($urandom_range(0, 3) == 0) begin
				n = pick_gap_len();
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		#10_000_000;
		$display("hsv_trilinear_histogram: mismatch");
		$finish;
	end

	initial begin : stimulus
		pix_req_t rq;
		int       n;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= 1'b0;
		in_valid <= 1'b0;
		func <= FUNC_ACC;
		hue_code <= '0;
		sat_code <= '0;
		val_code <= '0;
		cell_index <= '0;
		bin_index <= '0;

		add_row(dir_row(FUNC_READ, 0, 0, 0, 12'd0, 5'd0, 1, '0));
		add_row(dir_row(FUNC_READ, 0, 0, 0, 12'd4095, 5'd26, 1, '0));
		add_row(dir_row(FUNC_READ, 0, 0, 0, 12'd5, 5'd31, 1, '0));
		// soft vote at the low corner: hue wraps, saturation and value drop
		add_row(dir_row(FUNC_ACC, 0, 0, 0, 12'd1, 5'd0, 0, '0));
		add_row(dir_row(FUNC_READ, 0, 0, 0, 12'd1, 5'd0, 0, '0));
		add_row(dir_row(FUNC_ACC, 255, 255, 255, 12'd1, 5'd0, 0, '0));
		add_row(dir_row(FUNC_READ, 0, 0, 0, 12'd1, 5'd26, 0, '0));
		add_row(dir_row(FUNC_READ, 0, 0, 0, 12'd1, 5'd2, 0, '0));
		// centre of the cube puts the whole weight on the middle bin
		add_row(dir_row(FUNC_ACC, 128, 128, 128, 12'd2, 5'd31, 0, '0));
		add_row(dir_row(FUNC_READ, 0, 0, 0, 12'd2, 5'd13, 1, ONE_Q24));
		add_row(dir_row(FUNC_NONE, 9, 9, 9, 12'd2, 5'd13, 0, '0));
		add_row(dir_row(FUNC_CLEAR, 255, 255, 255, 12'd2, 5'd13, 0, '0));
		add_row(dir_row(FUNC_READ, 0, 0, 0, 12'd2, 5'd13, 1, '0));
		add_row(dir_row(FUNC_CLEAR, 0, 0, 0, 12'd1, 5'd30, 0, '0));
		add_row(dir_row(FUNC_READ, 0, 0, 0, 12'd1, 5'd0, 0, '0));
		add_row(cfg_row(1'b0));
		add_row(dir_row(FUNC_ACC, 255, 255, 255, 12'd4, 5'd0, 0, '0));
		add_row(dir_row(FUNC_READ, 0, 0, 0, 12'd4, 5'd26, 1, ONE_Q24));
		add_row(dir_row(FUNC_ACC, 0, 0, 0, 12'd4095, 5'd0, 0, '0));
		add_row(dir_row(FUNC_READ, 0, 0, 0, 12'd4095, 5'd0, 1, ONE_Q24));
		add_row(dir_row(FUNC_ACC, 85, 86, 171, 12'd4, 5'd0, 0, '0));
		add_row(dir_row(FUNC_READ, 0, 0, 0, 12'd4, 5'd21, 1, ONE_Q24));
		add_row(cfg_row(1'b1));
		add_row(dir_row(FUNC_READ, 0, 0, 0, 12'd4095, 5'd0, 1, ONE_Q24));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				write_interp(dir_rows[i].cfg_val);
			end else begin
				tx_pause();
				send_request(dir_rows[i].req, dir_rows[i].given, dir_rows[i].given_value);
			end
		end

		// soft voting, with one full drain and one long receiver hold-off
		run_random(25);
		drain_results();
		run_random(10);
		hold_off_req = 1'b1;
		for (n = 0; n < 15; n++) begin
			rq = make_random_request();
			rq.fn = FUNC_READ;
			send_request(rq, 1'b0, '0);
		end
		run_random(15);

		write_interp(1'b0);
		run_random(15);

		// drive one bin past its ceiling with hard votes
		for (n = 0; n < 520; n++) begin
			rq = make_random_request();
			rq.fn = (n % 100 == 99) ? FUNC_READ : FUNC_ACC;
			rq.hue = 8'($urandom_range(0, 85));
			rq.sat = 8'($urandom_range(0, 85));
			rq.val = 8'($urandom_range(0, 85));
			rq.cell_idx = 12'd9;
			if (rq.fn == FUNC_READ) rq.bin_idx = 5'd0;
			tx_pause();
			send_request(rq, 1'b0, '0);
		end
		send_request('{fn: FUNC_READ, hue: 0, sat: 0, val: 0, cell_idx: 12'd9,
			bin_idx: 5'd0}, 1'b1, ACC_MAX);

		write_interp(1'b1);
		send_request('{fn: FUNC_ACC, hue: 0, sat: 0, val: 0, cell_idx: 12'd9,
			bin_idx: 5'd0}, 1'b0, '0);
		send_request('{fn: FUNC_READ, hue: 0, sat: 0, val: 0, cell_idx: 12'd9,
			bin_idx: 5'd0}, 1'b1, ACC_MAX);
		send_request('{fn: FUNC_READ, hue: 0, sat: 0, val: 0, cell_idx: 12'd9,
			bin_idx: 5'd2}, 1'b0, '0);
		run_random(10);

		drain_results();
		if (mismatch_count == 0) begin
			$display("hsv_trilinear_histogram: match");
		end else begin
			$display("hsv_trilinear_histogram: mismatch");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/hsvh_pkg.sv
hw/rtl/hsvh_ram.sv
hw/rtl/hsvh_ctrl.sv
hw/rtl/hsvh_dp.sv
hw/rtl/hsv_trilinear_histogram.sv
tb/hsv_trilinear_histogram_test.sv
